### design/lsc_pkg.sv
// lsc_pkg: shared types, codes and helpers for the link session client controller.
// No dependencies; imported by the interfaces, the step logic, the top level and the checker.
package lsc_pkg;

    // Field widths
    localparam int unsigned CMD_W    = 4;
    localparam int unsigned SEQ_W    = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned RATE_W   = 16;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned RTT_W    = 31;
    localparam int unsigned STATE_W  = 3;
    localparam int unsigned SEC_W    = 8;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 32;

    // Event codes
    localparam logic [CMD_W-1:0] CMD_TICK      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_REQUEST   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_AUTH      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ACK       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REJECT    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_REDIRECT  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_TDM       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_ECHO_REQ  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_ECHO_RESP = 4'd8;
    localparam logic [CMD_W-1:0] CMD_ERROR     = 4'd9;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SVC_REQ   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ECHO_REQ  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ECHO_RESP = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RTT       = 3'd4;
    localparam logic [ACT_W-1:0] ACT_TDM       = 3'd5;
    localparam logic [ACT_W-1:0] ACT_START     = 3'd6;

    // Session states
    localparam logic [STATE_W-1:0] ST_INIT       = 3'd0;
    localparam logic [STATE_W-1:0] ST_SENT       = 3'd1;
    localparam logic [STATE_W-1:0] ST_ACCEPTED   = 3'd2;
    localparam logic [STATE_W-1:0] ST_REJECTED   = 3'd3;
    localparam logic [STATE_W-1:0] ST_REDIRECTED = 3'd4;
    localparam logic [STATE_W-1:0] ST_WAIT       = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SERVICE_CODE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPABILITY_MASK = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_THRESHOLD  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRANSMIT      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALIVE_PERIOD    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_PERIOD     = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECONNECT       = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD            = 8'd7;

    // Configuration reset values
    localparam logic [SEC_W-1:0] RETRANSMIT_RST = 8'd10;
    localparam logic [SEC_W-1:0] ALIVE_RST      = 8'd3;
    localparam logic [SEC_W-1:0] ECHO_RST       = 8'd10;
    localparam logic [SEC_W-1:0] RECONNECT_RST  = 8'd10;
    localparam logic [SEC_W-1:0] DEAD_RST       = 8'd3;

    localparam logic [RTT_W-1:0] RTT_MAX = '1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SEQ_W-1:0]  seq_nr;
        logic [TIME_W-1:0] now_us;
        logic [RATE_W-1:0] underrun_rate;
        logic [RATE_W-1:0] overflow_rate;
    } t_item;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [SEQ_W-1:0]   out_seq;
        logic [RTT_W-1:0]   rtt_us;
        logic [STATE_W-1:0] session_state;
        logic               tdm_enabled;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [CFG_DAT_W-1:0] service_code;
        logic [CFG_DAT_W-1:0] capability_mask;
        logic [RATE_W-1:0]    rate_threshold;
        logic [SEC_W-1:0]     retransmit;
        logic [SEC_W-1:0]     alive_period;
        logic [SEC_W-1:0]     echo_period;
        logic [SEC_W-1:0]     reconnect;
        logic [SEC_W-1:0]     dead;
    } t_cfg;

    typedef struct packed {
        logic [STATE_W-1:0] fsm;
        logic [SEC_W-1:0]   state_timer;
        logic               timer_run;
        logic [SEC_W-1:0]   alive_timer;
        logic [SEC_W-1:0]   echo_timer;
        logic [SEC_W-1:0]   tdm_age;
        logic [SEQ_W-1:0]   echo_seq;
        logic [TIME_W-1:0]  echo_sent;
    } t_state;

    // A period of zero counts as one second
    function automatic logic [SEC_W-1:0] load_period(input logic [SEC_W-1:0] v);
        return (v == '0) ? {{(SEC_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

### design/lsc_evt_if.sv
// lsc_evt_if: event input channel (valid/ready plus event payload).
// Depends on lsc_pkg for field widths.
interface lsc_evt_if;
    import lsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [SEQ_W-1:0]    seq_nr;
    logic [TIME_W-1:0]   now_us;
    logic [RATE_W-1:0]   underrun_rate;
    logic [RATE_W-1:0]   overflow_rate;

    modport source (output valid, command, seq_nr, now_us, underrun_rate, overflow_rate,
                    input ready);
    modport sink   (input valid, command, seq_nr, now_us, underrun_rate, overflow_rate,
                    output ready);
endinterface

### design/lsc_res_if.sv
// lsc_res_if: result output channel (valid/ready plus action payload).
// Depends on lsc_pkg for field widths.
interface lsc_res_if;
    import lsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [SEQ_W-1:0]    out_seq;
    logic [RTT_W-1:0]    rtt_us;
    logic [STATE_W-1:0]  session_state;
    logic                tdm_enabled;
    logic                last;

    modport source (output valid, action, out_seq, rtt_us, session_state, tdm_enabled, last,
                    input ready);
    modport sink   (input valid, action, out_seq, rtt_us, session_state, tdm_enabled, last,
                    output ready);
endinterface

### design/lsc_cfg_if.sv
// lsc_cfg_if: configuration write channel (valid/ready, register index, write data).
// Depends on lsc_pkg for field widths.
interface lsc_cfg_if;
    import lsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/link_session_client_fsm.sv
// link_session_client_fsm: client session controller for a circuit-over-IP link.
// Depends on lsc_pkg, lsc_evt_if, lsc_res_if, lsc_cfg_if and lsc_step.
//
//  channel  | dir | payload                                                 | handshake
//  ---------+-----+---------------------------------------------------------+-----------
//  i_evt    | in  | command, seq_nr, now_us, underrun_rate, overflow_rate   | valid/ready
//  o_res    | out | action, out_seq, rtt_us, session_state, tdm_enabled,    | valid/ready
//           |     | last                                                    |
//  i_cfg    | in  | index, data                                             | valid/ready
//
// Every event yields exactly one result (last always set), offered on o_res once it has
// passed through the input register and then the output register.
// One event per cycle sustained while o_res is ready: an input register feeds the step
// logic, whose result and next state are captured in the output register and the session
// registers together. Reset is synchronous; it clears session state and loads the
// register defaults. A stalled output holds both stages; the input takes a new transfer
// as soon as its register moves on. Configuration writes are always accepted.
module link_session_client_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsc_evt_if.sink     i_evt,
    lsc_res_if.source   o_res,
    lsc_cfg_if.sink     i_cfg
);
    import lsc_pkg::*;

    t_item   r_item;
    logic    r_item_valid;
    t_result r_out;
    logic    r_out_valid;
    t_state  r_state;
    t_state  n_state;
    t_result n_out;
    t_cfg    r_cfg;
    logic    advance;
    logic    evt_xfer;

    assign advance     = !r_out_valid || o_res.ready;
    assign i_evt.ready = !r_item_valid || advance;
    assign evt_xfer    = i_evt.valid && i_evt.ready;
    assign i_cfg.ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_item_valid <= i_evt.valid;
        end
        if (evt_xfer) begin
            r_item.command       <= i_evt.command;
            r_item.seq_nr        <= i_evt.seq_nr;
            r_item.now_us        <= i_evt.now_us;
            r_item.underrun_rate <= i_evt.underrun_rate;
            r_item.overflow_rate <= i_evt.overflow_rate;
        end
    end

    lsc_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Session state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (advance) begin
            r_out_valid <= r_item_valid;
            if (r_item_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_item_valid) begin
            r_out <= n_out;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.service_code    <= '0;
            r_cfg.capability_mask <= '0;
            r_cfg.rate_threshold  <= '0;
            r_cfg.retransmit      <= RETRANSMIT_RST;
            r_cfg.alive_period    <= ALIVE_RST;
            r_cfg.echo_period     <= ECHO_RST;
            r_cfg.reconnect       <= RECONNECT_RST;
            r_cfg.dead            <= DEAD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SERVICE_CODE:    r_cfg.service_code    <= i_cfg.data;
                REG_CAPABILITY_MASK: r_cfg.capability_mask <= i_cfg.data;
                REG_RATE_THRESHOLD:  r_cfg.rate_threshold  <= i_cfg.data[RATE_W-1:0];
                REG_RETRANSMIT:      r_cfg.retransmit      <= i_cfg.data[SEC_W-1:0];
                REG_ALIVE_PERIOD:    r_cfg.alive_period    <= i_cfg.data[SEC_W-1:0];
                REG_ECHO_PERIOD:     r_cfg.echo_period     <= i_cfg.data[SEC_W-1:0];
                REG_RECONNECT:       r_cfg.reconnect       <= i_cfg.data[SEC_W-1:0];
                REG_DEAD:            r_cfg.dead            <= i_cfg.data[SEC_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.action        = r_out.action;
    assign o_res.out_seq       = r_out.out_seq;
    assign o_res.rtt_us        = r_out.rtt_us;
    assign o_res.session_state = r_out.session_state;
    assign o_res.tdm_enabled   = r_out.tdm_enabled;
    assign o_res.last          = r_out.last;

endmodule

### design/lsc_step.sv
// lsc_step: next-state and result logic for one event of the session controller.
// Purely combinational; depends on lsc_pkg.
module lsc_step (
    input  lsc_pkg::t_state  i_state,
    input  lsc_pkg::t_cfg    i_cfg,
    input  lsc_pkg::t_item   i_item,
    output lsc_pkg::t_state  o_state,
    output lsc_pkg::t_result o_result
);
    import lsc_pkg::*;

    t_state              s;
    logic [ACT_W-1:0]    act;
    logic [SEQ_W-1:0]    seq;
    logic [TIME_W-1:0]   diff;
    logic                halt;

    // Round trip time, modulo 2^32 and saturated
    assign diff = i_item.now_us - i_state.echo_sent;

    always_comb begin
        s    = i_state;
        act  = ACT_NONE;
        seq  = '0;
        halt = 1'b0;
        case (i_item.command)
            CMD_TICK: begin
                // TDM age, saturating
                if (s.tdm_age != '1) begin
                    s.tdm_age = s.tdm_age + 8'd1;
                end
                // state timer: retransmit or reconnect
                if (s.timer_run) begin
                    if (s.state_timer <= 8'd1) begin
                        s.state_timer = '0;
                        s.timer_run   = 1'b0;
                        if (s.fsm inside {ST_SENT, ST_WAIT}) begin
                            s.fsm         = ST_SENT;
                            s.state_timer = load_period(i_cfg.retransmit);
                            s.timer_run   = 1'b1;
                            act           = ACT_SVC_REQ;
                        end
                    end else begin
                        s.state_timer = s.state_timer - 8'd1;
                    end
                end
                if (s.fsm == ST_ACCEPTED) begin
                    // liveness and rate checks
                    if (s.alive_timer <= 8'd1) begin
                        s.alive_timer = '0;
                        if (s.tdm_age > i_cfg.dead) begin
                            s.fsm         = ST_SENT;
                            s.state_timer = load_period(i_cfg.retransmit);
                            s.timer_run   = 1'b1;
                            act           = ACT_SVC_REQ;
                            halt          = 1'b1;
                        end else if (i_item.underrun_rate > i_cfg.rate_threshold ||
                                     i_item.overflow_rate > i_cfg.rate_threshold) begin
                            s.fsm         = ST_WAIT;
                            s.state_timer = load_period(i_cfg.reconnect);
                            s.timer_run   = 1'b1;
                            halt          = 1'b1;
                        end else begin
                            s.alive_timer = load_period(i_cfg.alive_period);
                        end
                    end else begin
                        s.alive_timer = s.alive_timer - 8'd1;
                    end
                    // echo request
                    if (!halt) begin
                        if (s.echo_timer <= 8'd1) begin
                            s.echo_seq   = s.echo_seq + 16'd1;
                            s.echo_sent  = i_item.now_us;
                            s.echo_timer = load_period(i_cfg.echo_period);
                            act          = ACT_ECHO_REQ;
                            seq          = s.echo_seq;
                        end else begin
                            s.echo_timer = s.echo_timer - 8'd1;
                        end
                    end
                end
            end
            CMD_REQUEST: begin
                if (s.fsm == ST_INIT) begin
                    s.fsm         = ST_SENT;
                    s.state_timer = load_period(i_cfg.retransmit);
                    s.timer_run   = 1'b1;
                    act           = ACT_SVC_REQ;
                end
            end
            CMD_ACK: begin
                if (s.fsm == ST_SENT) begin
                    s.fsm         = ST_ACCEPTED;
                    s.state_timer = '0;
                    s.timer_run   = 1'b0;
                    s.tdm_age     = '0;
                    s.alive_timer = load_period(i_cfg.alive_period);
                    s.echo_timer  = load_period(i_cfg.echo_period);
                    act           = ACT_START;
                end
            end
            CMD_REJECT: begin
                if (s.fsm == ST_SENT) begin
                    s.fsm         = ST_REJECTED;
                    s.state_timer = '0;
                    s.timer_run   = 1'b0;
                end
            end
            CMD_REDIRECT: begin
                if (s.fsm == ST_SENT) begin
                    s.fsm         = ST_REDIRECTED;
                    s.state_timer = '0;
                    s.timer_run   = 1'b0;
                end
            end
            CMD_TDM: begin
                if (s.fsm == ST_ACCEPTED) begin
                    s.tdm_age = '0;
                    act       = ACT_TDM;
                end
            end
            CMD_ECHO_REQ: begin
                act = ACT_ECHO_RESP;
                seq = i_item.seq_nr;
            end
            CMD_ECHO_RESP: begin
                if (i_item.seq_nr == s.echo_seq) begin
                    act = ACT_RTT;
                end
            end
            default: begin
                // auth, error and unknown codes: no action
            end
        endcase
    end

    assign o_state                = s;
    assign o_result.action        = act;
    assign o_result.out_seq       = seq;
    assign o_result.rtt_us        = (act != ACT_RTT) ? '0 :
                                    (diff[TIME_W-1] ? RTT_MAX : diff[RTT_W-1:0]);
    assign o_result.session_state = s.fsm;
    assign o_result.tdm_enabled   = (s.fsm == ST_ACCEPTED);
    assign o_result.last          = 1'b1;

endmodule

### design/lsc_checker.sv
// lsc_checker: port-level checks on the session controller's result channel.
// Depends on lsc_pkg; bound to link_session_client_fsm at the end of this file.
module lsc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [lsc_pkg::ACT_W-1:0]   i_action,
    input logic [lsc_pkg::RTT_W-1:0]   i_rtt_us,
    input logic [lsc_pkg::STATE_W-1:0] i_session_state,
    input logic                        i_tdm_enabled,
    input logic                        i_last
);
    import lsc_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // one result per event, so every result closes its event
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_last)
        else $error("result without last");

    // permission flag follows the reported state
    a_permit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_tdm_enabled == (i_session_state == ST_ACCEPTED)))
        else $error("tdm_enabled disagrees with session_state");

    // line start, echo requests and forwarding only happen while accepted
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_action == ACT_START || i_action == ACT_ECHO_REQ ||
                        i_action == ACT_TDM)
        |-> i_session_state == ST_ACCEPTED)
        else $error("session action outside accepted state");

    // round trip time only on rtt reports
    a_rtt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_action != ACT_RTT |-> i_rtt_us == '0)
        else $error("rtt_us set on other action");

endmodule

bind link_session_client_fsm lsc_checker u_lsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_action        (o_res.action),
    .i_rtt_us        (o_res.rtt_us),
    .i_session_state (o_res.session_state),
    .i_tdm_enabled   (o_res.tdm_enabled),
    .i_last          (o_res.last)
);
